// ===== rtl/pbi_pkg.sv =====
`default_nettype none

package pbi_pkg;

  localparam int unsigned FIFO_DEPTH_DFLT = 256;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // bus function codes
  localparam logic [2:0] FUNC_SLEEP = 3'd0;
  localparam logic [2:0] FUNC_LINE0 = 3'd1;
  localparam logic [2:0] FUNC_LINE1 = 3'd2;
  localparam logic [2:0] FUNC_LINE2 = 3'd3;
  localparam logic [2:0] FUNC_LINE3 = 3'd4;
  localparam logic [2:0] FUNC_READ  = 3'd5;
  localparam logic [2:0] FUNC_WRITE = 3'd6;
  localparam logic [2:0] FUNC_ACK   = 3'd7;

  // line3 command bytes
  localparam logic [7:0] L3_CMD_PRINT = 8'h00;
  localparam logic [7:0] L3_CMD_FEED  = 8'h04;
  localparam logic [7:0] L3_CMD_RECV  = 8'h05;

  localparam logic [15:0] WIN_ROM2_LO = 16'h2000;
  localparam logic [15:0] WIN_ROM2_HI = 16'h3000;
  localparam logic [15:0] WIN_BANK_LO = 16'h4000;
  localparam logic [15:0] WIN_BANK_HI = 16'h8000;
  localparam logic [17:0] ROM2_BASE   = 18'h20000;
  localparam logic [7:0]  DATA_OPEN   = 8'h7f;
  localparam logic [7:0]  STATUS_IDLE = 8'hff;
  localparam logic [8:0]  X_MAX       = 9'd320;
  localparam logic [11:0] FEED_STEP   = 12'd10;
  localparam logic [11:0] TOP_RESET   = 12'd10;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  func;
    logic        is_write;
    logic [2:0]  dest;
    logic [15:0] addr;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic        resp_valid;
    logic [2:0]  resp_func;
    logic [7:0]  resp_data;
    logic        resp_int;
    logic        rom_read;
    logic [17:0] rom_addr;
    logic        col_valid;
    logic [7:0]  col_bits;
    logic [8:0]  col_x;
    logic [11:0] line_top;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICK,
    OP_L0_RD,
    OP_L1_RD,
    OP_L2_RD,
    OP_L3_RD,
    OP_L0_WR,
    OP_L1_WR,
    OP_L2_WR,
    OP_L3_WR,
    OP_READ,
    OP_WRITE,
    OP_ACK
  } op_e;

  typedef enum logic [1:0] {
    RGN_OPEN,
    RGN_ROM2,
    RGN_BANK
  } rgn_e;

  typedef enum logic [1:0] {
    L3_OTHER,
    L3_PRINT,
    L3_RECV,
    L3_FEED
  } l3_e;

  // classified request handed from front to back
  typedef struct packed {
    op_e         kind;
    logic [7:0]  data;
    logic [13:0] addr_lo;
    rgn_e        rgn;
    logic        onehot;
    logic [2:0]  bank;
    l3_e         l3;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/pbi_if.sv =====
`default_nettype none

interface pbi_in_if import pbi_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface pbi_out_if import pbi_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== rtl/printer_bus_interface_unit.sv =====
// Bus interface of a column printer.
// in_i: one request per accepted item, either a bus access (cmd 0) or a
//   column tick (cmd 1). Handshake valid/ready; accepted when both are high.
// out_o: exactly one result per request, in order, same handshake.
// Path: a request accepted on in_i is classified into a 2-entry queue, then
//   executed from the queue head into the output register and shown on out_o.
// Throughput: one request per cycle without a stall, set by the single
//   execute stage that updates flags, head position and column FIFO pointers.
// Columns live in a FIFO_DEPTH-byte RAM; its registered read delivers
//   col_bits together with the result that popped it.
// Reset: all flags and FIFO pointers clear, head_top is 10, head_x is 0.
//   RAM contents are undefined; only written bytes are ever popped.
// Receiver stall: the output register holds its result, execution pauses,
//   the queue fills and in_i.ready drops once two requests wait in it.
`default_nettype none

module printer_bus_interface_unit import pbi_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DFLT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pbi_in_if.sink    in_i,
  pbi_out_if.source out_o
);

  logic q_ready, q_valid, push, pop;
  op_t  front_op, back_op;

  pbi_front u_front (
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .op_o      (front_op)
  );

  pbi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (pop),
    .op_o    (back_op)
  );

  pbi_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .op_i      (back_op),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/pbi_ram.sv =====
`default_nettype none

module pbi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pbi_front.sv =====
`default_nettype none

module pbi_front import pbi_pkg::*; (
  pbi_in_if.sink    in_i,
  input  wire logic q_ready_i,
  output logic      push_o,
  output op_t       op_o
);

  in_item_t it;

  assign it         = in_i.item;
  assign in_i.ready = q_ready_i;
  assign push_o     = in_i.valid && q_ready_i;

  always_comb begin
    op_o         = '0;
    op_o.kind    = OP_NONE;
    op_o.data    = it.data;
    op_o.addr_lo = it.addr[13:0];
    op_o.onehot  = $onehot(it.data);
    op_o.bank    = '0;
    for (int b = 0; b < 8; b++) begin
      if (it.data == (8'd1 << b)) begin
        op_o.bank = 3'(7 - b);
      end
    end

    if (it.addr >= WIN_ROM2_LO && it.addr < WIN_ROM2_HI) begin
      op_o.rgn = RGN_ROM2;
    end else if (it.addr >= WIN_BANK_LO && it.addr < WIN_BANK_HI) begin
      op_o.rgn = RGN_BANK;
    end else begin
      op_o.rgn = RGN_OPEN;
    end

    unique case (it.data)
      L3_CMD_PRINT: op_o.l3 = L3_PRINT;
      L3_CMD_RECV:  op_o.l3 = L3_RECV;
      L3_CMD_FEED:  op_o.l3 = L3_FEED;
      default:      op_o.l3 = L3_OTHER;
    endcase

    if (it.cmd) begin
      op_o.kind = OP_TICK;
    end else if (it.func != FUNC_SLEEP && it.dest == 3'd0) begin
      unique case (it.func)
        FUNC_LINE0: op_o.kind = it.is_write ? OP_L0_WR : OP_L0_RD;
        FUNC_LINE1: op_o.kind = it.is_write ? OP_L1_WR : OP_L1_RD;
        FUNC_LINE2: op_o.kind = it.is_write ? OP_L2_WR : OP_L2_RD;
        FUNC_LINE3: op_o.kind = it.is_write ? OP_L3_WR : OP_L3_RD;
        FUNC_READ:  op_o.kind = OP_READ;
        FUNC_WRITE: op_o.kind = OP_WRITE;
        FUNC_ACK:   op_o.kind = OP_ACK;
        default:    op_o.kind = OP_NONE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pbi_queue.sv =====
`default_nettype none

module pbi_queue import pbi_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  op_t       op_i,
  output logic      ready_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output op_t       op_o
);

  localparam int unsigned QW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  op_t           slot_q [QUEUE_DEPTH];
  logic [QW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign ready_o = cnt_q != CW'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign op_o    = slot_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pbi_back.sv =====
`default_nettype none

module pbi_back import pbi_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DFLT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  op_t       op_i,
  output logic      pop_o,
  pbi_out_if.source out_o
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  logic          powered_q, powered_d;
  logic [2:0]    bank_q, bank_d;
  logic          recv_q, recv_d;
  logic          int_q, int_d;
  logic          print_q, print_d;
  logic          feed_q, feed_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] head_q, head_d;
  logic [8:0]    x_q, x_d;
  logic [11:0]   top_q, top_d;

  logic          exec;
  logic          ram_we, ram_re;
  logic [SW-1:0] wsum;
  logic [AW-1:0] waddr;
  logic [7:0]    ram_rdata;
  out_item_t     res_d, res_q;
  logic          ovalid_q;

  assign exec  = q_valid_i && (!ovalid_q || out_o.ready);
  assign pop_o = exec;

  // write slot is head + count, wrapped at the depth
  assign wsum  = SW'(head_q) + SW'(cnt_q);
  assign waddr = (wsum >= SW'(FIFO_DEPTH)) ? AW'(wsum - SW'(FIFO_DEPTH)) : AW'(wsum);

  pbi_ram #(
    .Width (8),
    .Depth (FIFO_DEPTH)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (op_i.data),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    powered_d = powered_q;
    bank_d    = bank_q;
    recv_d    = recv_q;
    int_d     = int_q;
    print_d   = print_q;
    feed_d    = feed_q;
    cnt_d     = cnt_q;
    head_d    = head_q;
    x_d       = x_q;
    top_d     = top_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    res_d     = '0;

    if (exec) begin
      // housekeeping before the request itself
      if (print_q) begin
        if (cnt_q != '0) begin
          if (op_i.kind == OP_TICK) begin
            ram_re          = 1'b1;
            head_d          = (head_q == AW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
            cnt_d           = cnt_q - 1'b1;
            res_d.col_valid = 1'b1;
            res_d.col_x     = x_q;
            x_d             = (x_q == X_MAX) ? '0 : x_q + 1'b1;
          end
        end else begin
          print_d = 1'b0;
        end
      end else if (feed_q) begin
        feed_d = 1'b0;
        top_d  = top_q + FEED_STEP;
        x_d    = '0;
        int_d  = 1'b1;
      end

      unique case (op_i.kind) inside
        OP_L0_RD: begin
          res_d.resp_valid = 1'b1;
          res_d.resp_func  = FUNC_READ;
        end
        OP_L1_RD, OP_L0_WR, OP_ACK: begin
          res_d.resp_valid = powered_q;
          res_d.resp_func  = FUNC_ACK;
          res_d.resp_data  = op_i.data;
        end
        OP_WRITE: begin
          res_d.resp_valid = powered_q;
          res_d.resp_func  = FUNC_WRITE;
          res_d.resp_data  = op_i.data;
        end
        OP_L2_RD: begin
          res_d.resp_valid = 1'b1;
          res_d.resp_func  = FUNC_READ;
          res_d.resp_data  = {7'd0, print_d};
        end
        OP_L3_RD: begin
          res_d.resp_valid = 1'b1;
          res_d.resp_func  = FUNC_READ;
          if (int_d) begin
            res_d.resp_int = 1'b1;
            int_d          = 1'b0;
          end else begin
            res_d.resp_data = STATUS_IDLE;
          end
        end
        OP_L1_WR: begin
          if (recv_q) begin
            if (cnt_q < CW'(FIFO_DEPTH)) begin
              ram_we = 1'b1;
              cnt_d  = cnt_q + 1'b1;
            end
            int_d = 1'b1;
          end
          res_d.resp_valid = powered_q;
          res_d.resp_func  = FUNC_ACK;
          res_d.resp_data  = op_i.data;
        end
        OP_L2_WR: begin
          powered_d = op_i.onehot;
          if (op_i.onehot) begin
            bank_d = op_i.bank;
          end
          res_d.resp_valid = op_i.onehot;
          res_d.resp_func  = FUNC_READ;
          res_d.resp_data  = 8'd1;
        end
        OP_L3_WR: begin
          case (op_i.l3)
            L3_PRINT: begin
              print_d = 1'b1;
              int_d   = 1'b0;
            end
            L3_RECV: begin
              cnt_d  = '0;
              head_d = '0;
              recv_d = 1'b1;
              int_d  = 1'b1;
            end
            L3_FEED: feed_d = 1'b1;
            default: ;
          endcase
          res_d.resp_valid = powered_q;
          res_d.resp_func  = FUNC_ACK;
          res_d.resp_data  = op_i.data;
        end
        OP_READ: begin
          res_d.resp_valid = powered_q;
          res_d.resp_func  = FUNC_READ;
          case (op_i.rgn)
            RGN_ROM2: begin
              res_d.rom_read = 1'b1;
              res_d.rom_addr = ROM2_BASE + 18'(op_i.addr_lo[11:0]);
            end
            RGN_BANK: begin
              res_d.rom_read  = 1'b1;
              res_d.resp_func = FUNC_ACK;
              res_d.rom_addr  = {1'b0, bank_q, op_i.addr_lo};
            end
            default: res_d.resp_data = DATA_OPEN;
          endcase
        end
        default: ;
      endcase

      if (!res_d.resp_valid) begin
        res_d.resp_func = '0;
        res_d.resp_data = '0;
        res_d.resp_int  = 1'b0;
        res_d.rom_read  = 1'b0;
        res_d.rom_addr  = '0;
      end
      res_d.line_top = top_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      powered_q <= 1'b0;
      bank_q    <= '0;
      recv_q    <= 1'b0;
      int_q     <= 1'b0;
      print_q   <= 1'b0;
      feed_q    <= 1'b0;
      cnt_q     <= '0;
      head_q    <= '0;
      x_q       <= '0;
      top_q     <= TOP_RESET;
      ovalid_q  <= 1'b0;
    end else begin
      powered_q <= powered_d;
      bank_q    <= bank_d;
      recv_q    <= recv_d;
      int_q     <= int_d;
      print_q   <= print_d;
      feed_q    <= feed_d;
      cnt_q     <= cnt_d;
      head_q    <= head_d;
      x_q       <= x_d;
      top_q     <= top_d;
      if (exec) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_q <= res_d;
    end
  end

  // column byte arrives from the RAM read register, which only moves on a pop
  always_comb begin
    out_o.item          = res_q;
    out_o.item.col_bits = res_q.col_valid ? ram_rdata : 8'd0;
  end
  assign out_o.valid = ovalid_q;

endmodule

`default_nettype wire

// ===== rtl/pbi_checker.sv =====
`default_nettype none

module pbi_checker import pbi_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input out_item_t out_item_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("result changed while stalled");

  a_idle_resp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.resp_valid |->
      out_item_i.resp_func == 3'd0 && out_item_i.resp_data == 8'd0 &&
      !out_item_i.resp_int && !out_item_i.rom_read && out_item_i.rom_addr == 18'd0)
    else $error("response fields set without a response");

  a_col_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.col_valid |->
      out_item_i.col_x <= X_MAX && !out_item_i.resp_valid)
    else $error("bad column result");

  a_rom_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.rom_read |->
      out_item_i.resp_valid && out_item_i.resp_data == 8'd0 &&
      (out_item_i.resp_func == FUNC_READ || out_item_i.resp_func == FUNC_ACK))
    else $error("bad ROM read response");

endmodule

bind printer_bus_interface_unit pbi_checker u_pbi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.item)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pbi_pkg::*;

  localparam int unsigned CDEPTH       = FIFO_DEPTH_DFLT;
  localparam int unsigned HW           = $clog2(CDEPTH);
  localparam int unsigned RANDOM_REQS  = 1050;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_PRINTED  = 40;

  logic clk_i;
  logic rst_ni;

  pbi_in_if  req_if ();
  pbi_out_if rsp_if ();

  printer_bus_interface_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // printer state as seen from the bus
  logic          pr_powered, pr_receiving, pr_int, pr_printing, pr_feed;
  logic [2:0]    pr_bank;
  logic [7:0]    col_store [CDEPTH];
  logic [HW:0]   pr_count;
  logic [HW-1:0] pr_head;
  logic [8:0]    pr_x;
  logic [11:0]   pr_top;

  in_item_t  pending_reqs[$];
  out_item_t predicted_replies[$];

  int unsigned total_reqs   = 0;
  int unsigned reqs_taken   = 0;
  int unsigned replies_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned cols_printed = 0;
  int unsigned x_wraps      = 0;
  int unsigned rom_hits     = 0;
  int unsigned bytes_lost   = 0;
  int unsigned feeds_done   = 0;
  int unsigned req_gap      = 0;
  int unsigned rsp_stall    = 0;
  bit          req_taken    = 1'b0;
  bit          steady       = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t bus_req(logic [2:0] fn, logic wr, logic [15:0] a, logic [7:0] d);
    in_item_t r;
    r.cmd      = 1'b0;
    r.func     = fn;
    r.is_write = wr;
    r.dest     = '0;
    r.addr     = a;
    r.data     = d;
    return r;
  endfunction

  function automatic in_item_t tick_req();
    in_item_t r;
    r     = in_item_t'($urandom);
    r.cmd = 1'b1;
    return r;
  endfunction

  task automatic advance_printer(input in_item_t rq, output out_item_t rs);
    logic          done;
    logic [HW-1:0] slot;
    int            i;
    rs = '0;
    // housekeeping runs before the request itself
    if (pr_printing) begin
      if (pr_count != 0) begin
        if (rq.cmd) begin
          rs.col_valid = 1'b1;
          rs.col_bits  = col_store[pr_head];
          rs.col_x     = pr_x;
          pr_head      = pr_head + 1'b1;
          pr_count     = pr_count - 1'b1;
          cols_printed++;
          if (pr_x >= X_MAX) begin
            pr_x = '0;
            x_wraps++;
          end else begin
            pr_x = pr_x + 1'b1;
          end
        end
      end else begin
        pr_printing = 1'b0;
      end
    end else if (pr_feed) begin
      pr_feed = 1'b0;
      pr_top  = pr_top + FEED_STEP;
      pr_x    = '0;
      pr_int  = 1'b1;
      feeds_done++;
    end

    if (!rq.cmd && rq.func != FUNC_SLEEP && rq.dest == '0) begin
      done         = 1'b0;
      rs.resp_func = rq.func;
      rs.resp_data = rq.data;
      if (!rq.is_write) begin
        case (rq.func)
          FUNC_LINE0: begin
            rs.resp_valid = 1'b1;
            rs.resp_func  = FUNC_READ;
            rs.resp_data  = '0;
            done          = 1'b1;
          end
          FUNC_LINE1: rs.resp_func = FUNC_ACK;
          FUNC_LINE2: begin
            rs.resp_valid = 1'b1;
            rs.resp_func  = FUNC_READ;
            rs.resp_data  = {7'd0, pr_printing};
            done          = 1'b1;
          end
          FUNC_LINE3: begin
            if (pr_int) begin
              rs.resp_int  = 1'b1;
              rs.resp_data = '0;
              pr_int       = 1'b0;
            end else begin
              rs.resp_data = STATUS_IDLE;
            end
            rs.resp_valid = 1'b1;
            rs.resp_func  = FUNC_READ;
            done          = 1'b1;
          end
          default: ;
        endcase
      end else begin
        case (rq.func)
          FUNC_LINE0: rs.resp_func = FUNC_ACK;
          FUNC_LINE1: begin
            if (pr_receiving) begin
              if (pr_count < CDEPTH) begin
                slot            = pr_head + pr_count[HW-1:0];
                col_store[slot] = rq.data;
                pr_count        = pr_count + 1'b1;
              end else begin
                bytes_lost++;
              end
              pr_int = 1'b1;
            end
            rs.resp_func = FUNC_ACK;
          end
          FUNC_LINE2: begin
            // one-hot byte: bit 0 selects the top bank
            pr_powered = 1'b0;
            for (i = 0; i < 8; i++) begin
              if (rq.data == (8'd1 << i)) begin
                pr_powered = 1'b1;
                pr_bank    = 3'(7 - i);
              end
            end
            if (pr_powered) begin
              rs.resp_valid = 1'b1;
              rs.resp_func  = FUNC_READ;
              rs.resp_data  = 8'd1;
            end
            done = 1'b1;
          end
          FUNC_LINE3: begin
            if (rq.data == L3_CMD_PRINT) begin
              pr_printing = 1'b1;
              pr_int      = 1'b0;
            end else if (rq.data == L3_CMD_RECV) begin
              pr_count     = '0;
              pr_head      = '0;
              pr_receiving = 1'b1;
              pr_int       = 1'b1;
            end else if (rq.data == L3_CMD_FEED) begin
              pr_feed = 1'b1;
            end
            rs.resp_func = FUNC_ACK;
          end
          default: ;
        endcase
      end

      if (!done && pr_powered) begin
        rs.resp_valid = 1'b1;
        if (rs.resp_func == FUNC_READ) begin
          if (rq.addr >= WIN_ROM2_LO && rq.addr < WIN_ROM2_HI) begin
            rs.rom_read  = 1'b1;
            rs.resp_data = '0;
            rs.rom_addr  = ROM2_BASE + 18'(rq.addr - WIN_ROM2_LO);
          end else if (rq.addr >= WIN_BANK_LO && rq.addr < WIN_BANK_HI) begin
            rs.rom_read  = 1'b1;
            rs.resp_data = '0;
            rs.resp_func = FUNC_ACK;
            rs.rom_addr  = 18'(rq.addr - WIN_BANK_LO) + (18'(pr_bank) << 14);
          end else begin
            rs.resp_data = DATA_OPEN;
          end
        end
      end
      if (!rs.resp_valid) begin
        rs.resp_func = '0;
        rs.resp_data = '0;
        rs.resp_int  = 1'b0;
        rs.rom_read  = 1'b0;
        rs.rom_addr  = '0;
      end
      if (rs.rom_read) rom_hits++;
    end
    rs.line_top = pr_top;
  endtask

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    out_item_t got, want;
    if (rst_ni) begin
      cycle_cnt++;
      if (cycle_cnt % 200 == 0) steady = ($urandom_range(0, 3) == 0);

      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.item;
        replies_seen++;
        if (predicted_replies.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending: %h",
                                    replies_seen, got));
        end else begin
          want = predicted_replies.pop_front();
          if (got.resp_valid !== want.resp_valid)
            report_mismatch($sformatf("#%0d resp_valid got %0h want %0h",
                                      replies_seen, got.resp_valid, want.resp_valid));
          if (got.resp_func !== want.resp_func)
            report_mismatch($sformatf("#%0d resp_func got %0h want %0h",
                                      replies_seen, got.resp_func, want.resp_func));
          if (got.resp_data !== want.resp_data)
            report_mismatch($sformatf("#%0d resp_data got %0h want %0h",
                                      replies_seen, got.resp_data, want.resp_data));
          if (got.resp_int !== want.resp_int)
            report_mismatch($sformatf("#%0d resp_int got %0h want %0h",
                                      replies_seen, got.resp_int, want.resp_int));
          if (got.rom_read !== want.rom_read)
            report_mismatch($sformatf("#%0d rom_read got %0h want %0h",
                                      replies_seen, got.rom_read, want.rom_read));
          if (got.rom_addr !== want.rom_addr)
            report_mismatch($sformatf("#%0d rom_addr got %0h want %0h",
                                      replies_seen, got.rom_addr, want.rom_addr));
          if (got.col_valid !== want.col_valid)
            report_mismatch($sformatf("#%0d col_valid got %0h want %0h",
                                      replies_seen, got.col_valid, want.col_valid));
          if (got.col_bits !== want.col_bits)
            report_mismatch($sformatf("#%0d col_bits got %0h want %0h",
                                      replies_seen, got.col_bits, want.col_bits));
          if (got.col_x !== want.col_x)
            report_mismatch($sformatf("#%0d col_x got %0d want %0d",
                                      replies_seen, got.col_x, want.col_x));
          if (got.line_top !== want.line_top)
            report_mismatch($sformatf("#%0d line_top got %0d want %0d",
                                      replies_seen, got.line_top, want.line_top));
        end
      end

      req_taken = req_if.valid && req_if.ready;
      if (req_taken) begin
        advance_printer(req_if.item, want);
        predicted_replies.push_back(want);
        reqs_taken++;
      end
    end
  end

  // request source and result sink, both driven on the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      rsp_if.ready <= 1'b0;
    end else begin
      if (!req_if.valid || req_taken) begin
        if (req_gap != 0) begin
          req_if.valid <= 1'b0;
          req_gap--;
        end else if (pending_reqs.size() != 0) begin
          req_if.item  <= pending_reqs.pop_front();
          req_if.valid <= 1'b1;
          req_gap = pick_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end

      if (rsp_stall != 0) begin
        rsp_if.ready <= 1'b0;
        rsp_stall--;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) rsp_stall = pick_gap();
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d of %0d requests taken",
             cycle_cnt, reqs_taken, total_reqs);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    in_item_t r;
    int       n, i, target;
    bit       flooded;

    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.item  = '0;
    rsp_if.ready = 1'b0;

    pr_powered   = 1'b0;
    pr_receiving = 1'b0;
    pr_int       = 1'b0;
    pr_printing  = 1'b0;
    pr_feed      = 1'b0;
    pr_bank      = '0;
    pr_count     = '0;
    pr_head      = '0;
    pr_x         = '0;
    pr_top       = TOP_RESET;
    flooded      = 1'b0;

    // directed: status reads, power, ROM windows, echoes, ignored requests,
    // a short receive / print / feed cycle
    pending_reqs.push_back(bus_req(FUNC_LINE0, 1'b0, 16'h0000, 8'hff));
    pending_reqs.push_back(bus_req(FUNC_LINE2, 1'b0, 16'hffff, 8'h00));
    pending_reqs.push_back(bus_req(FUNC_LINE3, 1'b0, 16'h1234, 8'h00));
    pending_reqs.push_back(bus_req(FUNC_READ,  1'b0, 16'h2000, 8'h00));  // powered off
    pending_reqs.push_back(bus_req(FUNC_LINE2, 1'b1, 16'h0000, 8'h03));  // not one-hot
    pending_reqs.push_back(bus_req(FUNC_LINE2, 1'b1, 16'h0000, 8'h80));
    pending_reqs.push_back(bus_req(FUNC_READ,  1'b0, 16'h4000, 8'hff));
    pending_reqs.push_back(bus_req(FUNC_LINE2, 1'b1, 16'h0000, 8'h01));
    pending_reqs.push_back(bus_req(FUNC_READ,  1'b0, 16'h7fff, 8'h00));
    pending_reqs.push_back(bus_req(FUNC_READ,  1'b1, 16'h2000, 8'h00));
    pending_reqs.push_back(bus_req(FUNC_READ,  1'b0, 16'h2fff, 8'h00));
    pending_reqs.push_back(bus_req(FUNC_READ,  1'b0, 16'hffff, 8'h00));
    pending_reqs.push_back(bus_req(FUNC_WRITE, 1'b1, 16'h0000, 8'hff));
    pending_reqs.push_back(bus_req(FUNC_ACK,   1'b0, 16'hffff, 8'h00));
    pending_reqs.push_back(bus_req(FUNC_SLEEP, 1'b1, 16'h0000, 8'h55));
    r      = bus_req(FUNC_LINE0, 1'b0, 16'h0000, 8'h00);
    r.dest = 3'd7;
    pending_reqs.push_back(r);
    pending_reqs.push_back(bus_req(FUNC_LINE0, 1'b1, 16'h0000, 8'h12));
    pending_reqs.push_back(bus_req(FUNC_LINE1, 1'b0, 16'h0000, 8'h34));
    pending_reqs.push_back(bus_req(FUNC_LINE3, 1'b1, 16'h0000, 8'h07));
    pending_reqs.push_back(bus_req(FUNC_LINE3, 1'b1, 16'h0000, L3_CMD_RECV));
    pending_reqs.push_back(bus_req(FUNC_LINE3, 1'b0, 16'h0000, 8'h00));
    pending_reqs.push_back(bus_req(FUNC_LINE1, 1'b1, 16'h0000, 8'ha5));
    pending_reqs.push_back(bus_req(FUNC_LINE1, 1'b1, 16'h0000, 8'h5a));
    pending_reqs.push_back(bus_req(FUNC_LINE3, 1'b1, 16'h0000, L3_CMD_PRINT));
    pending_reqs.push_back(tick_req());
    pending_reqs.push_back(bus_req(FUNC_LINE2, 1'b0, 16'h0000, 8'h00));  // busy
    pending_reqs.push_back(tick_req());
    pending_reqs.push_back(tick_req());
    pending_reqs.push_back(bus_req(FUNC_LINE3, 1'b1, 16'h0000, L3_CMD_FEED));
    pending_reqs.push_back(tick_req());
    pending_reqs.push_back(bus_req(FUNC_LINE3, 1'b0, 16'h0000, 8'h00));

    target = pending_reqs.size() + RANDOM_REQS;
    while (pending_reqs.size() < target) begin
      if (!flooded && pending_reqs.size() > 300) begin
        // overrun the column FIFO, print it out, then push the head past
        // the right margin with a second run without a feed
        flooded = 1'b1;
        pending_reqs.push_back(bus_req(FUNC_LINE3, 1'b1, 16'($urandom), L3_CMD_RECV));
        for (i = 0; i < CDEPTH + 4; i++)
          pending_reqs.push_back(bus_req(FUNC_LINE1, 1'b1, 16'($urandom), 8'($urandom)));
        pending_reqs.push_back(bus_req(FUNC_LINE3, 1'b1, 16'($urandom), L3_CMD_PRINT));
        for (i = 0; i < CDEPTH + 2; i++) pending_reqs.push_back(tick_req());
        pending_reqs.push_back(bus_req(FUNC_LINE3, 1'b1, 16'($urandom), L3_CMD_RECV));
        for (i = 0; i < 70; i++)
          pending_reqs.push_back(bus_req(FUNC_LINE1, 1'b1, 16'($urandom), 8'($urandom)));
        pending_reqs.push_back(bus_req(FUNC_LINE3, 1'b1, 16'($urandom), L3_CMD_PRINT));
        for (i = 0; i < 72; i++) pending_reqs.push_back(tick_req());
      end
      case ($urandom_range(0, 9))
        0: begin
          pending_reqs.push_back(bus_req(FUNC_LINE2, 1'b1, 16'($urandom),
            ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'd1 << $urandom_range(0, 7)));
        end
        1, 2: begin
          pending_reqs.push_back(bus_req(FUNC_LINE3, 1'b1, 16'($urandom), L3_CMD_RECV));
          n = $urandom_range(1, 24);
          for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) pending_reqs.push_back(in_item_t'($urandom));
            else pending_reqs.push_back(bus_req(FUNC_LINE1, 1'b1, 16'($urandom), 8'($urandom)));
          end
        end
        3, 4: begin
          pending_reqs.push_back(bus_req(FUNC_LINE3, 1'b1, 16'($urandom), L3_CMD_PRINT));
          n = $urandom_range(1, 30);
          for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0)
              pending_reqs.push_back(bus_req(FUNC_LINE2, 1'b0, 16'($urandom), 8'($urandom)));
            else pending_reqs.push_back(tick_req());
          end
        end
        5: begin
          pending_reqs.push_back(bus_req(FUNC_LINE3, 1'b1, 16'($urandom), L3_CMD_FEED));
          n = $urandom_range(0, 2);
          for (i = 0; i < n; i++) pending_reqs.push_back(tick_req());
          pending_reqs.push_back(bus_req(FUNC_LINE3, 1'b0, 16'($urandom), 8'($urandom)));
        end
        6: begin
          n = $urandom_range(1, 5);
          for (i = 0; i < n; i++)
            pending_reqs.push_back(bus_req(3'($urandom_range(FUNC_LINE0, FUNC_LINE3)),
                                           1'($urandom), 16'($urandom),
                                           ($urandom_range(0, 1) == 0) ?
                                             8'($urandom_range(0, 7)) : 8'($urandom)));
        end
        7: begin
          n = $urandom_range(1, 6);
          for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
              0: r = bus_req(FUNC_READ, 1'($urandom),
                             16'(WIN_ROM2_LO + $urandom_range(0, 16'h0fff)), 8'($urandom));
              1: r = bus_req(FUNC_READ, 1'($urandom),
                             16'(WIN_BANK_LO + $urandom_range(0, 16'h3fff)), 8'($urandom));
              2: r = bus_req(FUNC_READ, 1'($urandom), 16'($urandom), 8'($urandom));
              default: r = bus_req(3'($urandom_range(FUNC_WRITE, FUNC_ACK)), 1'($urandom),
                                   16'($urandom), 8'($urandom));
            endcase
            pending_reqs.push_back(r);
          end
        end
        8: begin
          n = $urandom_range(1, 4);
          for (i = 0; i < n; i++) pending_reqs.push_back(in_item_t'($urandom));
        end
        default: begin
          // broken sequences: bytes and ticks with no setup in front
          n = $urandom_range(1, 4);
          for (i = 0; i < n; i++) begin
            r      = in_item_t'($urandom);
            r.dest = '0;
            pending_reqs.push_back(r);
          end
        end
      endcase
    end
    total_reqs = pending_reqs.size();

    repeat (12) @(posedge clk_i);
    #1 rst_ni = 1'b1;

    do @(negedge clk_i);
    while (reqs_taken != total_reqs || predicted_replies.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (predicted_replies.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", predicted_replies.size()));

    $display("%0d bus requests and ticks, %0d results checked, %0d mismatches",
             reqs_taken, replies_seen, mismatches);
    $display("%0d columns printed, %0d margin wraps, %0d line feeds, %0d ROM reads, %0d bytes lost to a full FIFO",
             cols_printed, x_wraps, feeds_done, rom_hits, bytes_lost);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== printer_bus_interface_unit.f =====
rtl/pbi_pkg.sv
rtl/pbi_if.sv
rtl/pbi_ram.sv
rtl/pbi_front.sv
rtl/pbi_queue.sv
rtl/pbi_back.sv
rtl/printer_bus_interface_unit.sv
rtl/pbi_checker.sv
tb/sv/tb_top.sv
